// ----- rtl/core/ssh_pkg.sv -----
// Shared types, constants and segment tables for the seven-segment hex calculator.
// Used by the interfaces, the configuration block, the divider and the top level.
// Depends on nothing.
package ssh_pkg;

	// Field and datapath widths.
	localparam int SWITCH_WIDTH_DEF = 10;
	localparam int SWITCH_FIELD_W   = 10;
	localparam int OPERAND_W        = 16;
	localparam int DIGIT_W          = 4;
	localparam int SEG_W            = 8;
	localparam int VALUE_W          = 24;
	localparam int READ_W           = 32;
	localparam int SEG_LOW_W        = 32;
	localparam int SEG_HIGH_W       = 16;
	localparam int VALUE_DIGITS     = 6;
	localparam int OPERAND_DIGITS   = 4;
	localparam int APB_DATA_W       = 32;
	localparam int CFG_ADDR_W       = 3;

	// Input word modes.
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_KEY   = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	// Key codes; each is a single captured key edge.
	localparam logic [3:0] KEY_ADD = 4'b1000;
	localparam logic [3:0] KEY_SUB = 4'b0100;
	localparam logic [3:0] KEY_DIV = 4'b0010;
	localparam logic [3:0] KEY_MUL = 4'b0001;

	// Configuration register indexes.
	localparam logic REG_BLANK_LEADING = 1'b0;
	localparam logic REG_BLINK_ENABLE  = 1'b1;

	// Fixed display words.
	localparam logic [SEG_HIGH_W-1:0] HIGH_OVERFLOW   = 16'h7900;
	localparam logic [SEG_HIGH_W-1:0] HIGH_NEGATIVE   = 16'h0079;
	localparam logic [SEG_HIGH_W-1:0] HIGH_CLEAR      = 16'h0000;
	localparam logic [OPERAND_W-1:0]  DIV_ZERO_RESULT = 16'hFFFF;
	localparam logic [READ_W-1:0]     READ_RESET      = 32'hFFFF_FFFF;

	// Configuration state handed to the core.
	typedef struct packed {
		logic blank_leading;
		logic blink_enable;
		logic blink_clear;
	} cfg_t;

	// Hex digit to segment pattern (segment a in bit 0).
	function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] p;
		unique case (d)
			4'h0: p = 8'h3F;
			4'h1: p = 8'h06;
			4'h2: p = 8'h5B;
			4'h3: p = 8'h4F;
			4'h4: p = 8'h66;
			4'h5: p = 8'h6D;
			4'h6: p = 8'h7D;
			4'h7: p = 8'h07;
			4'h8: p = 8'h7F;
			4'h9: p = 8'h67;
			4'hA: p = 8'h77;
			4'hB: p = 8'h7C;
			4'hC: p = 8'h39;
			4'hD: p = 8'h5E;
			4'hE: p = 8'h79;
			4'hF: p = 8'h71;
		endcase
		return p;
	endfunction

	// Segment pattern back to a hex digit; a dark or unknown pattern reads as zero.
	function automatic logic [DIGIT_W-1:0] seg_to_digit(input logic [SEG_W-1:0] p);
		logic [DIGIT_W-1:0] d;
		unique case (p)
			8'h06:   d = 4'h1;
			8'h5B:   d = 4'h2;
			8'h4F:   d = 4'h3;
			8'h66:   d = 4'h4;
			8'h6D:   d = 4'h5;
			8'h7D:   d = 4'h6;
			8'h07:   d = 4'h7;
			8'h7F:   d = 4'h8;
			8'h67:   d = 4'h9;
			8'h77:   d = 4'hA;
			8'h7C:   d = 4'hB;
			8'h39:   d = 4'hC;
			8'h5E:   d = 4'hD;
			8'h79:   d = 4'hE;
			8'h71:   d = 4'hF;
			default: d = 4'h0;
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/core/ssh_if.sv -----
// Valid/ready channel interfaces for the calculator's input and result words.
// Depends on ssh_pkg for field widths.
interface ssh_in_if;
	import ssh_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [1:0]                mode;
	logic [VALUE_W-1:0]        new_value;
	logic [3:0]                key_edges;
	logic [SWITCH_FIELD_W-1:0] switches;

	modport source (output valid, mode, new_value, key_edges, switches, input ready);
	modport sink   (input valid, mode, new_value, key_edges, switches, output ready);
endinterface

interface ssh_out_if;
	import ssh_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [SEG_LOW_W-1:0]  segments_low;
	logic [SEG_HIGH_W-1:0] segments_high;
	logic [READ_W-1:0]     read_data;

	modport source (output valid, segments_low, segments_high, read_data, input ready);
	modport sink   (input valid, segments_low, segments_high, read_data, output ready);
endinterface

// ----- rtl/core/ssh_cfg.sv -----
// APB-style register file holding the blanking and blink controls.
// Depends on ssh_pkg for the register indexes and the cfg_t struct.
module ssh_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ssh_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [ssh_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ssh_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output ssh_pkg::cfg_t                    cfg
);
	import ssh_pkg::*;

	logic blank_leading_q;
	logic blink_enable_q;
	logic wr_en;
	logic reg_idx;

	// A write completes in the access cycle; registers sit at 4-byte steps.
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[CFG_ADDR_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_leading_q <= 1'b0;
			blink_enable_q  <= 1'b0;
		end else if (wr_en) begin
			if (reg_idx == REG_BLANK_LEADING) begin
				blank_leading_q <= pwdata[0];
			end else begin
				blink_enable_q <= pwdata[0];
			end
		end
	end

	// Read back the addressed register.
	always_comb begin
		prdata = '0;
		if (reg_idx == REG_BLANK_LEADING) begin
			prdata[0] = blank_leading_q;
		end else begin
			prdata[0] = blink_enable_q;
		end
	end

	// Turning blink off also forces the display back on.
	assign cfg.blank_leading = blank_leading_q;
	assign cfg.blink_enable  = blink_enable_q;
	assign cfg.blink_clear   = wr_en && (reg_idx == REG_BLINK_ENABLE) && !pwdata[0];

endmodule

// ----- rtl/core/ssh_div.sv -----
// Restoring divider, one quotient bit per cycle, for the calculator's divide key.
// Depends on ssh_pkg for the operand width.
module ssh_div #(
	parameter int SWITCH_WIDTH = ssh_pkg::SWITCH_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [ssh_pkg::OPERAND_W-1:0]   dividend,
	input  logic [SWITCH_WIDTH-1:0]         divisor,
	output logic                            done,
	output logic [ssh_pkg::OPERAND_W-1:0]   quotient
);
	import ssh_pkg::*;

	localparam int STEP_W = $clog2(OPERAND_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(OPERAND_W - 1);

	logic                    busy_q;
	logic                    done_q;
	logic [STEP_W-1:0]       step_q;
	logic [SWITCH_WIDTH-1:0] rem_q;
	logic [SWITCH_WIDTH-1:0] dsr_q;
	logic [OPERAND_W-1:0]    quot_q;
	logic [SWITCH_WIDTH:0]   trial;
	logic [SWITCH_WIDTH:0]   diff;
	logic                    fits;

	// Bring down the next dividend bit and try to subtract the divisor.
	always_comb begin
		trial = {rem_q, quot_q[OPERAND_W-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dsr_q  <= divisor;
			quot_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[SWITCH_WIDTH-1:0] : trial[SWITCH_WIDTH-1:0];
			quot_q <= {quot_q[OPERAND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ----- rtl/core/seven_segment_hex_calculator.sv -----
// Top level of the seven-segment hex calculator: digit-serial sequencer and display state.
// Depends on ssh_pkg, ssh_if, ssh_cfg and ssh_div.
//
//   channel  direction  handshake          contents
//   req      in         valid/ready        mode, new_value, key_edges, switches
//   rsp      out        valid/ready        segments_low, segments_high, read_data
//   apb      in         psel/penable       blank_leading (0x0), blink_enable (0x4)
//
// A write word is encoded one digit per cycle, top digit first.
// A key word serves add, subtract or multiply, or a divide, by a nonzero switch value through the
// one-bit-per-cycle divider; four digits are decoded and re-encoded serially.
// Tick, read and unknown-key words pass from idle straight to the done state. One word is in work at a time.
// A finished word waits in the output register; a new word is taken meanwhile.
// Reset clears the display to dark segments and sets the read value to all ones.
module seven_segment_hex_calculator #(
	parameter int SWITCH_WIDTH = ssh_pkg::SWITCH_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ssh_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [ssh_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ssh_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	ssh_in_if.sink                           req,
	ssh_out_if.source                        rsp
);
	import ssh_pkg::*;

	localparam int CNT_W = $clog2(VALUE_DIGITS);
	localparam int PROD_W = OPERAND_W + SWITCH_WIDTH;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ENC  = 7'b0000010,
		ST_DEC  = 7'b0000100,
		ST_CALC = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_RES  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	cfg_t cfg;

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        cnt_q, cnt_d;
	logic                    nz_q, nz_d;
	logic [SEG_LOW_W-1:0]    shown_low_q, shown_low_d;
	logic [SEG_HIGH_W-1:0]   shown_high_q, shown_high_d;
	logic [READ_W-1:0]       last_written_q, last_written_d;
	logic                    blank_phase_q, blank_phase_d;
	logic                    out_valid_q, out_valid_d;

	logic [VALUE_W-1:0]      val_q, val_d;
	logic [OPERAND_W-1:0]    a_q, a_d;
	logic [SWITCH_WIDTH-1:0] sw_q, sw_d;
	logic [3:0]              key_q, key_d;
	logic [OPERAND_W-1:0]    res_q, res_d;
	logic [SEG_LOW_W-1:0]    out_low_q, out_low_d;
	logic [SEG_HIGH_W-1:0]   out_high_q, out_high_d;
	logic [READ_W-1:0]       out_read_q, out_read_d;

	logic                    in_fire;
	logic                    key_ok;
	logic                    out_load;
	logic [DIGIT_W-1:0]      enc_digit;
	logic                    enc_nz;
	logic                    enc_lit;
	logic [SEG_W-1:0]        enc_byte;
	logic [OPERAND_W:0]      sum;
	logic [OPERAND_W-1:0]    sw_ext;
	logic [OPERAND_W-1:0]    diff;
	logic [PROD_W-1:0]       prod;
	logic                    div_start;
	logic                    div_done;
	logic [OPERAND_W-1:0]    quotient;

	ssh_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ssh_div #(
		.SWITCH_WIDTH (SWITCH_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (a_q),
		.divisor  (sw_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Handshakes.
	assign req.ready = (state_q == ST_IDLE);
	assign in_fire   = req.valid && (state_q == ST_IDLE);
	assign key_ok    = (req.key_edges == KEY_ADD) || (req.key_edges == KEY_SUB) ||
	                   (req.key_edges == KEY_DIV) || (req.key_edges == KEY_MUL);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// Write encoding: with blanking on, a digit stays dark only above the highest nonzero digit.
	always_comb begin
		enc_digit = val_q[VALUE_W-1 -: DIGIT_W];
		enc_nz    = nz_q || (enc_digit != '0);
		enc_lit   = !cfg.blank_leading || enc_nz || (cnt_q == '0);
		enc_byte  = enc_lit ? seg_of(enc_digit) : '0;
	end

	// Arithmetic on the decoded operand and the switch value.
	always_comb begin
		sw_ext = OPERAND_W'(sw_q);
		sum    = {1'b0, a_q} + {1'b0, sw_ext};
		diff   = a_q - sw_ext;
		prod   = PROD_W'(a_q) * PROD_W'(sw_q);
	end

	// Sequencer and next-state logic.
	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		nz_d           = nz_q;
		shown_low_d    = shown_low_q;
		shown_high_d   = shown_high_q;
		last_written_d = last_written_q;
		blank_phase_d  = blank_phase_q;
		out_valid_d    = out_valid_q;
		val_d          = val_q;
		a_d            = a_q;
		sw_d           = sw_q;
		key_d          = key_q;
		res_d          = res_q;
		out_low_d      = out_low_q;
		out_high_d     = out_high_q;
		out_read_d     = out_read_q;
		div_start      = 1'b0;

		if (cfg.blink_clear) begin
			blank_phase_d = 1'b0;
		end

		if (rsp.ready) begin
			out_valid_d = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					// Only the low SWITCH_WIDTH bits of the switch field take part.
					sw_d    = SWITCH_WIDTH'(req.switches);
					key_d   = req.key_edges;
					state_d = ST_DONE;
					unique case (req.mode)
						MODE_WRITE: begin
							val_d          = req.new_value;
							last_written_d = READ_W'(req.new_value);
							nz_d           = 1'b0;
							cnt_d          = CNT_W'(VALUE_DIGITS - 1);
							state_d        = ST_ENC;
						end
						MODE_KEY: begin
							if (key_ok) begin
								cnt_d   = CNT_W'(OPERAND_DIGITS - 1);
								state_d = ST_DEC;
							end
						end
						MODE_TICK: begin
							if (cfg.blink_enable) begin
								blank_phase_d = !blank_phase_q;
							end
						end
						MODE_READ: begin
						end
					endcase
				end
			end
			ST_ENC: begin
				// Top digit enters first and ends up in the high byte of shown_high.
				{shown_high_d, shown_low_d} = {shown_high_q[SEG_W-1:0], shown_low_q, enc_byte};
				val_d = {val_q[VALUE_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
				nz_d  = enc_nz;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DEC: begin
				// Digit 3 is decoded first, so the operand builds up most significant first.
				a_d         = {a_q[OPERAND_W-DIGIT_W-1:0], seg_to_digit(shown_low_q[SEG_LOW_W-1 -: SEG_W])};
				shown_low_d = {shown_low_q[SEG_LOW_W-SEG_W-1:0], {SEG_W{1'b0}}};
				cnt_d       = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				cnt_d        = CNT_W'(OPERAND_DIGITS - 1);
				state_d      = ST_RES;
				shown_high_d = HIGH_CLEAR;
				unique case (key_q)
					KEY_ADD: begin
						res_d = sum[OPERAND_W-1:0];
						if (sum[OPERAND_W]) begin
							shown_high_d = HIGH_OVERFLOW;
						end
					end
					KEY_SUB: begin
						res_d = diff;
						if (sw_ext > a_q) begin
							shown_high_d = HIGH_NEGATIVE;
						end
					end
					KEY_MUL: begin
						res_d = prod[OPERAND_W-1:0];
						if (prod[PROD_W-1:OPERAND_W] != '0) begin
							shown_high_d = HIGH_OVERFLOW;
						end
					end
					KEY_DIV: begin
						if (sw_q == '0) begin
							res_d        = DIV_ZERO_RESULT;
							shown_high_d = HIGH_NEGATIVE;
						end else begin
							div_start = 1'b1;
							state_d   = ST_DIV;
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_DIV: begin
				if (div_done) begin
					res_d   = quotient;
					state_d = ST_RES;
				end
			end
			ST_RES: begin
				// Re-encode the 16-bit result one digit per cycle, top digit first.
				shown_low_d = {shown_low_q[SEG_LOW_W-SEG_W-1:0], seg_of(res_q[OPERAND_W-1 -: DIGIT_W])};
				res_d       = {res_q[OPERAND_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
				cnt_d       = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					out_valid_d = 1'b1;
					out_low_d   = blank_phase_q ? '0 : shown_low_q;
					out_high_d  = blank_phase_q ? '0 : shown_high_q;
					out_read_d  = last_written_q;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control and display state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			nz_q           <= 1'b0;
			shown_low_q    <= '0;
			shown_high_q   <= '0;
			last_written_q <= READ_RESET;
			blank_phase_q  <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q        <= state_d;
			cnt_q          <= cnt_d;
			nz_q           <= nz_d;
			shown_low_q    <= shown_low_d;
			shown_high_q   <= shown_high_d;
			last_written_q <= last_written_d;
			blank_phase_q  <= blank_phase_d;
			out_valid_q    <= out_valid_d;
		end
	end

	// Working registers and the result word.
	always_ff @(posedge clk) begin
		val_q      <= val_d;
		a_q        <= a_d;
		sw_q       <= sw_d;
		key_q      <= key_d;
		res_q      <= res_d;
		out_low_q  <= out_low_d;
		out_high_q <= out_high_d;
		out_read_q <= out_read_d;
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.segments_low  = out_low_q;
	assign rsp.segments_high = out_high_q;
	assign rsp.read_data     = out_read_q;

endmodule

// ----- rtl/core/ssh_checker.sv -----
// Port-level checks for the seven-segment hex calculator, bound to the top level.
// Depends on ssh_pkg for field widths.
module ssh_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [ssh_pkg::SEG_LOW_W-1:0]  segments_low,
	input logic [ssh_pkg::SEG_HIGH_W-1:0] segments_high,
	input logic [ssh_pkg::READ_W-1:0]     read_data
);
	import ssh_pkg::*;

	logic [1:0] pending_q;
	logic       in_fire;
	logic       out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// Words taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_fire && !out_fire) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_fire && !in_fire) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(segments_low) &&
		$stable(segments_high) && $stable(read_data))
		else $error("result word changed while stalled");

	// At most one word in work plus one waiting in the output register.
	a_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> pending_q != 2'd2)
		else $error("word accepted with two words outstanding");

	// No result appears without a word behind it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result word without an accepted input word");

	// The read value is either a 24-bit written value or the reset pattern.
	a_read_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (read_data[READ_W-1:VALUE_W] != '0) |-> read_data == READ_RESET)
		else $error("read value is neither a written value nor the reset pattern");

endmodule

bind seven_segment_hex_calculator ssh_checker u_ssh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (req.valid),
	.in_ready      (req.ready),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.segments_low  (rsp.segments_low),
	.segments_high (rsp.segments_high),
	.read_data     (rsp.read_data)
);

// ----- tb/sv/seven_segment_hex_calculator_check.sv -----
// Checker for the seven-segment hex calculator: watches the word channels and the APB port,
// predicts every result word and compares it field by field with what the block returns.
// Depends on ssh_pkg for codes and widths and on ssh_if for the channel interfaces.
module seven_segment_hex_calculator_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ssh_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [ssh_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [ssh_pkg::APB_DATA_W-1:0] prdata,
	input  logic                           pready,
	ssh_in_if                              req,
	ssh_out_if                             rsp,
	output int                             fail_count,
	output int                             pending,
	output int                             checked
);
	import ssh_pkg::*;

	// Segment pattern of each hex digit, digit 0 first.
	localparam logic [SEG_W-1:0] GLYPH [16] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h67, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
	};

	// Error marks on the two high digits.
	localparam logic [SEG_HIGH_W-1:0] MARK_OVERFLOW = 16'h7900;
	localparam logic [SEG_HIGH_W-1:0] MARK_NEGATIVE = 16'h0079;
	localparam logic [OPERAND_W-1:0]  DIV_BY_ZERO   = 16'hFFFF;

	localparam logic [CFG_ADDR_W-1:0] ADDR_BLANK = {REG_BLANK_LEADING, 2'b00};
	localparam logic [CFG_ADDR_W-1:0] ADDR_BLINK = {REG_BLINK_ENABLE, 2'b00};

	typedef struct {
		logic [SEG_LOW_W-1:0]  seg_low;
		logic [SEG_HIGH_W-1:0] seg_high;
		logic [READ_W-1:0]     read_back;
	} display_word_t;

	// Predicted display state and register copies.
	logic [SEG_LOW_W-1:0]  shadow_low;
	logic [SEG_HIGH_W-1:0] shadow_high;
	logic [READ_W-1:0]     last_value;
	logic                  dark;
	logic                  lead_blank;
	logic                  blink_on;

	display_word_t display_expect_q[$];

	// A pattern that is no digit reads back as zero.
	function automatic logic [DIGIT_W-1:0] glyph_digit(input logic [SEG_W-1:0] pattern);
		for (int d = 0; d < 16; d++) begin
			if (GLYPH[d] == pattern)
				return d[DIGIT_W-1:0];
		end
		return '0;
	endfunction

	function automatic logic [SEG_LOW_W-1:0] glyphs16(input logic [OPERAND_W-1:0] v);
		logic [SEG_LOW_W-1:0] r;
		r = '0;
		for (int k = 0; k < OPERAND_DIGITS; k++)
			r[SEG_W*k +: SEG_W] = GLYPH[v[DIGIT_W*k +: DIGIT_W]];
		return r;
	endfunction

	function automatic logic [APB_DATA_W-1:0] register_value(input logic [CFG_ADDR_W-1:0] a);
		if (a == ADDR_BLANK)
			return {{(APB_DATA_W-1){1'b0}}, lead_blank};
		if (a == ADDR_BLINK)
			return {{(APB_DATA_W-1){1'b0}}, blink_on};
		return '0;
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("MISMATCH %s: expected %h, got %h", what, want, got);
	endtask

	// Advance the display state by one accepted word and queue the word the block must return.
	task automatic predict_display(input logic [1:0] mode, input logic [VALUE_W-1:0] value,
			input logic [3:0] keys, input logic [9:0] sw);
		logic [SEG_W-1:0]     digit_seg [VALUE_DIGITS];
		logic [VALUE_W-1:0]   rest;
		logic                 dim;
		logic [31:0]          a;
		logic [31:0]          s;
		logic [31:0]          res;
		logic [SEG_HIGH_W-1:0] mark;
		display_word_t        w;

		case (mode)
			MODE_WRITE: begin
				// Once the remaining digits are all zero, blanking leaves them dark.
				last_value = {{(READ_W-VALUE_W){1'b0}}, value};
				rest = value;
				dim = 1'b0;
				for (int i = 0; i < VALUE_DIGITS; i++) begin
					if (i > 0 && lead_blank && rest == '0)
						dim = 1'b1;
					digit_seg[i] = dim ? 8'h00 : GLYPH[rest[3:0]];
					rest = rest >> DIGIT_W;
				end
				shadow_low  = {digit_seg[3], digit_seg[2], digit_seg[1], digit_seg[0]};
				shadow_high = {digit_seg[5], digit_seg[4]};
			end
			MODE_KEY: begin
				if (keys inside {KEY_ADD, KEY_SUB, KEY_DIV, KEY_MUL}) begin
					// The operand is read from the shadow display, never the blanked outputs.
					a = '0;
					for (int i = 0; i < OPERAND_DIGITS; i++)
						a[DIGIT_W*i +: DIGIT_W] = glyph_digit(shadow_low[SEG_W*i +: SEG_W]);
					s = {22'b0, sw};
					mark = '0;
					case (keys)
						KEY_ADD: begin
							res = a + s;
							if (res > 32'hFFFF)
								mark = MARK_OVERFLOW;
						end
						KEY_SUB: begin
							res = a - s;
							if (s > a)
								mark = MARK_NEGATIVE;
						end
						KEY_DIV: begin
							if (s == 0) begin
								res  = {16'b0, DIV_BY_ZERO};
								mark = MARK_NEGATIVE;
							end else begin
								res = a / s;
							end
						end
						default: begin
							res = a * s;
							if (res > 32'hFFFF)
								mark = MARK_OVERFLOW;
						end
					endcase
					shadow_low  = glyphs16(res[OPERAND_W-1:0]);
					shadow_high = mark;
				end
			end
			MODE_TICK: begin
				if (blink_on)
					dark = ~dark;
			end
			default: ;
		endcase

		w.seg_low   = dark ? '0 : shadow_low;
		w.seg_high  = dark ? '0 : shadow_high;
		w.read_back = last_value;
		display_expect_q.push_back(w);
	endtask

	// Watch the register port and both channels on every clock edge.
	always @(posedge clk or negedge arst_n) begin
		display_word_t want;
		if (!arst_n) begin
			shadow_low  = '0;
			shadow_high = '0;
			last_value  = '1;
			dark        = 1'b0;
			lead_blank  = 1'b0;
			blink_on    = 1'b0;
			display_expect_q.delete();
		end else begin
			// Register writes take effect at the access edge; reads are checked there.
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == ADDR_BLANK) begin
						lead_blank = pwdata[0];
					end else if (paddr == ADDR_BLINK) begin
						blink_on = pwdata[0];
						if (!pwdata[0])
							dark = 1'b0;
					end
				end else if (prdata !== register_value(paddr)) begin
					note_mismatch("register read", register_value(paddr), prdata);
				end
			end

			// Result words are matched against the oldest prediction.
			if (rsp.valid && rsp.ready) begin
				if (display_expect_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("MISMATCH unexpected result word: low %h high %h read %h",
							rsp.segments_low, rsp.segments_high, rsp.read_data);
				end else begin
					want = display_expect_q.pop_front();
					checked++;
					if (rsp.segments_low !== want.seg_low)
						note_mismatch("segments_low", want.seg_low, rsp.segments_low);
					if (rsp.segments_high !== want.seg_high)
						note_mismatch("segments_high", {16'b0, want.seg_high},
							{16'b0, rsp.segments_high});
					if (rsp.read_data !== want.read_back)
						note_mismatch("read_data", want.read_back, rsp.read_data);
				end
			end

			if (req.valid && req.ready)
				predict_display(req.mode, req.new_value, req.key_edges, req.switches);
		end
		pending = display_expect_q.size();
	end

endmodule

// ----- tb/sv/seven_segment_hex_calculator_test.sv -----
// Top of the seven-segment hex calculator testbench: clock, reset, word and register stimulus,
// receiver stalls and the verdict. Depends on ssh_pkg, ssh_if, the block and its checker.
module seven_segment_hex_calculator_test;
	import ssh_pkg::*;

	localparam int RANDOM_WORDS    = 800;
	localparam int RANDOM_PHASES   = 5;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 40;
	localparam int RUN_LIMIT       = 1000000;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SHUT} rx_pattern_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int mismatches;
	int results_due;
	int results_seen;

	int  burst_left;
	int  words_by_mode [4];
	int  settings_used;
	bit  hold_off_req;
	bit  hold_off_done;

	ssh_in_if  req_ch ();
	ssh_out_if rsp_ch ();

	seven_segment_hex_calculator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	seven_segment_hex_calculator_check display_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (mismatches),
		.pending    (results_due),
		.checked    (results_seen)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run.
	initial begin
		#RUN_LIMIT;
		$display("Test completed with failures");
		$finish;
	end

	// Offer one word and hold it until accepted; between bursts the sender goes quiet.
	task automatic offer_word(input logic [1:0] mode, input logic [VALUE_W-1:0] value,
			input logic [3:0] keys, input logic [9:0] sw);
		req_ch.valid     <= 1'b1;
		req_ch.mode      <= mode;
		req_ch.new_value <= value;
		req_ch.key_edges <= keys;
		req_ch.switches  <= sw;
		do @(posedge clk); while (!req_ch.ready);
		words_by_mode[mode]++;
		burst_left--;
		if (burst_left <= 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 24);
		end
	endtask

	// Stop offering and wait until every predicted word has come back.
	task automatic drain;
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
	endtask

	// APB write of one register followed by a read-back of it.
	task automatic reg_write(input logic index, input logic value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= {{(APB_DATA_W-1){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Receiver: changing stall patterns, and one long hold-off once asked for.
	initial begin
		rx_pattern_t pat;
		int          len;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_off_req && !hold_off_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end else begin
				pat = rx_pattern_t'($urandom_range(0, 3));
				len = (pat == RX_SHUT) ? $urandom_range(1, 15) : $urandom_range(4, 60);
				repeat (len) begin
					case (pat)
						RX_OPEN:   rsp_ch.ready <= 1'b1;
						RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
						RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
						default:   rsp_ch.ready <= 1'b0;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Stimulus: directed words, then random words under several register settings.
	initial begin
		logic [1:0]         mode;
		logic [VALUE_W-1:0] value;
		logic [3:0]         keys;
		logic [9:0]         sw;
		logic [1:0]         setting;
		logic [3:0]         op_keys [4];
		int                 pick;

		op_keys = '{KEY_ADD, KEY_SUB, KEY_DIV, KEY_MUL};
		hold_off_req  = 1'b0;
		settings_used = 1;
		burst_left    = $urandom_range(1, 24);
		words_by_mode = '{0, 0, 0, 0};

		arst_n           <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.mode      <= MODE_READ;
		req_ch.new_value <= '0;
		req_ch.key_edges <= '0;
		req_ch.switches  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state, dark digits as operand, ignored key values and every operation.
		offer_word(MODE_READ,  24'h0,      4'h0,    10'd0);
		offer_word(MODE_KEY,   24'h0,      KEY_ADD, 10'd5);
		offer_word(MODE_WRITE, 24'hFFFFFF, 4'h0,    10'd0);
		offer_word(MODE_KEY,   24'h0,      4'h0,    10'd1023);
		offer_word(MODE_KEY,   24'h0,      4'hF,    10'd1023);
		offer_word(MODE_WRITE, 24'h00FFFF, 4'h0,    10'd0);
		offer_word(MODE_KEY,   24'h0,      KEY_ADD, 10'd1023);
		offer_word(MODE_WRITE, 24'h000000, 4'h0,    10'd0);
		offer_word(MODE_KEY,   24'h0,      KEY_SUB, 10'd1);
		offer_word(MODE_KEY,   24'h0,      KEY_DIV, 10'd0);
		offer_word(MODE_WRITE, 24'h00ABCD, 4'h0,    10'd0);
		offer_word(MODE_KEY,   24'h0,      KEY_DIV, 10'd1023);
		offer_word(MODE_KEY,   24'h0,      KEY_MUL, 10'd1023);
		offer_word(MODE_WRITE, 24'h00FFFF, 4'h0,    10'd0);
		offer_word(MODE_KEY,   24'h0,      KEY_MUL, 10'd2);
		offer_word(MODE_TICK,  24'h0,      4'h0,    10'd0);
		drain();

		// Leading-zero blanking, and blanked digits feeding a key event.
		reg_write(REG_BLANK_LEADING, 1'b1);
		settings_used++;
		offer_word(MODE_WRITE, 24'h000120, 4'h0,    10'd0);
		offer_word(MODE_KEY,   24'h0,      KEY_ADD, 10'd1);
		offer_word(MODE_WRITE, 24'h000000, 4'h0,    10'd0);
		drain();

		// Blinking: write and key event while dark, then blink off clears the dark phase.
		reg_write(REG_BLINK_ENABLE, 1'b1);
		settings_used++;
		offer_word(MODE_TICK,  24'h0,      4'h0,    10'd0);
		offer_word(MODE_WRITE, 24'h123456, 4'h0,    10'd0);
		offer_word(MODE_KEY,   24'h0,      KEY_MUL, 10'd3);
		offer_word(MODE_READ,  24'h0,      4'h0,    10'd0);
		offer_word(MODE_TICK,  24'h0,      4'h0,    10'd0);
		offer_word(MODE_TICK,  24'h0,      4'h0,    10'd0);
		drain();
		reg_write(REG_BLINK_ENABLE, 1'b0);
		offer_word(MODE_READ,  24'h0,      4'h0,    10'd0);

		// Random words; each phase starts from an idle block with new register values.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       setting = 2'b00;
				1:       setting = 2'b11;
				2:       setting = 2'b10;
				3:       setting = 2'b01;
				default: setting = 2'($urandom_range(0, 3));
			endcase
			drain();
			reg_write(REG_BLANK_LEADING, setting[1]);
			reg_write(REG_BLINK_ENABLE, setting[0]);
			settings_used++;
			if (p == 0)
				hold_off_req = 1'b1;
			repeat (RANDOM_WORDS / RANDOM_PHASES) begin
				pick = $urandom_range(0, 99);
				mode = (pick < 25) ? MODE_WRITE : (pick < 70) ? MODE_KEY
					: (pick < 88) ? MODE_TICK : MODE_READ;
				pick = $urandom_range(0, 9);
				value = (pick == 0) ? 24'h000000 : (pick == 1) ? 24'hFFFFFF
					: (pick < 5) ? 24'($urandom_range(0, 255)) : 24'($urandom);
				keys = ($urandom_range(0, 99) < 85) ? op_keys[$urandom_range(0, 3)]
					: 4'($urandom_range(0, 15));
				pick = $urandom_range(0, 9);
				sw = (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023
					: (pick < 4) ? 10'($urandom_range(1, 16)) : 10'($urandom);
				offer_word(mode, value, keys, sw);
			end
		end

		// Wait for the last results and let the block settle.
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (results_due != 0)
			$display("%0d predicted result words never arrived", results_due);
		$display("Covered %0d writes, %0d key events, %0d ticks and %0d reads",
			words_by_mode[MODE_WRITE], words_by_mode[MODE_KEY], words_by_mode[MODE_TICK],
			words_by_mode[MODE_READ]);
		$display("under %0d settings; %0d result words compared, %0d mismatches.",
			settings_used, results_seen, mismatches);
		if (mismatches == 0 && results_due == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/ssh_pkg.sv
rtl/core/ssh_if.sv
rtl/core/ssh_cfg.sv
rtl/core/ssh_div.sv
rtl/core/seven_segment_hex_calculator.sv
rtl/core/ssh_checker.sv
tb/sv/seven_segment_hex_calculator_check.sv
tb/sv/seven_segment_hex_calculator_test.sv
